@@ rtl/core/aging_task_queue_assert.svh @@
// assertion macros for the aging task queue rtl
// expects signals named clk and rst in the scope of each use
`ifndef AGING_TASK_QUEUE_ASSERT_SVH
`define AGING_TASK_QUEUE_ASSERT_SVH

// same-cycle implication
`define ATQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aging_task_queue: same-cycle check failed");

// next-cycle implication
`define ATQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aging_task_queue: next-cycle check failed");

`endif

@@ rtl/core/atq_pkg.sv @@
// types, codes and sizes for the aging task queue
// no dependencies; used by atq_cell and aging_task_queue
package atq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 16;
  localparam int WAIT_W      = 16;
  localparam int OCC_W       = 5;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BIT_W       = $clog2(WAIT_W);

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
  localparam logic [WAIT_W-1:0] NEW_WAIT = WAIT_W'(1);

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_EXEC = 2'd1,
    KIND_KILL = 2'd2,
    KIND_NOP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RUN
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SCAN_LOAD,
    OP_SCAN,
    OP_PUSH,
    OP_POP,
    OP_KILL
  } cell_op_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] task_id;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  out_id;
    logic [WAIT_W-1:0] out_wait;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  task_id;
    logic [BIT_W-1:0] bit_sel;
    logic             any_hit;
  } cell_ctl_t;

endpackage

@@ rtl/core/aging_task_queue.sv @@
// aging task queue top level: sequencer, occupancy count and the row of slot cells
// depends on atq_pkg, atq_cell and aging_task_queue_assert.svh
//
//  channel   ports              handshake               word
//  command   cmd (cmd_t)        start high, busy low    kind, task_id
//  result    result (result_t)  done high for one cycle status, out_id, out_wait, occupancy
//
// enqueue, execute and no-op words latch the command on accept, then in the run state
// every cell updates at once where the word calls for it (shift, age or append)
// kill on a non-empty queue first passes through the scan state: the largest wait is found
// bit-serially, msb first, one wait bit per cycle across all cells in parallel
// done rises in the cycle busy drops, and a new start is taken in that same cycle
// rst is synchronous and active high; it clears the state, done and the count only,
// slot contents are undefined until written and never read before that
`include "aging_task_queue_assert.svh"

module aging_task_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  atq_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output atq_pkg::result_t result
);

  localparam int N = atq_pkg::QUEUE_DEPTH;

  // sequencer registers
  atq_pkg::state_t             state, state_next;
  logic [atq_pkg::CNT_W-1:0]   count, count_next;
  logic [atq_pkg::BIT_W-1:0]   bit_idx, bit_idx_next;
  atq_pkg::cmd_t               cmd_q;
  atq_pkg::result_t            result_next;
  logic                        done_next;

  atq_pkg::cell_ctl_t          ctl;

  // per-cell wiring
  logic [atq_pkg::ID_W-1:0]   slot_id   [N];
  logic [atq_pkg::WAIT_W-1:0] slot_wait [N];
  logic [atq_pkg::ID_W-1:0]   nxt_id    [N];
  logic [atq_pkg::WAIT_W-1:0] nxt_wait  [N];
  logic [N-1:0]               occ, tail, match, hit, cand, take_next, first;

  logic                       accept;
  logic                       dup, full, empty;
  logic [atq_pkg::ID_W-1:0]   kill_id;
  logic [atq_pkg::WAIT_W-1:0] kill_wait;

  // assertion helpers
  logic                       kill_run;
  logic                       push_now;

  assign accept = start && !busy;
  assign busy   = (state != atq_pkg::S_IDLE);
  assign dup    = |match;
  assign full   = (count >= atq_pkg::CNT_W'(N));
  assign empty  = (count == '0);

  // row of slot cells; each one pulls from its right neighbor on a shift
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i]  = (atq_pkg::CNT_W'(i) < count);
    assign tail[i] = (atq_pkg::CNT_W'(i) == count);

    if (i == N - 1) begin : g_last
      assign nxt_id[i]   = '0;
      assign nxt_wait[i] = '0;
    end else begin : g_mid
      assign nxt_id[i]   = slot_id[i+1];
      assign nxt_wait[i] = slot_wait[i+1];
    end

    atq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .tail      (tail[i]),
      .take_next (take_next[i]),
      .nxt_id    (nxt_id[i]),
      .nxt_wait  (nxt_wait[i]),
      .slot_id   (slot_id[i]),
      .slot_wait (slot_wait[i]),
      .match     (match[i]),
      .hit       (hit[i]),
      .cand      (cand[i])
    );
  end

  // earliest surviving candidate is the kill victim; it and every later cell shift
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < N; i++) begin
      first[i]     = cand[i] && !seen;
      seen         = seen || cand[i];
      take_next[i] = seen;
    end
  end

  // one-hot select of the victim's id and wait
  always_comb begin
    kill_id   = '0;
    kill_wait = '0;
    for (int i = 0; i < N; i++) begin
      kill_id   = kill_id   | (slot_id[i]   & {atq_pkg::ID_W{first[i]}});
      kill_wait = kill_wait | (slot_wait[i] & {atq_pkg::WAIT_W{first[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= atq_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    bit_idx <= bit_idx_next;
    result  <= result_next;
    if (accept) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    bit_idx_next = bit_idx;
    done_next    = 1'b0;
    result_next  = result;

    ctl.op      = atq_pkg::OP_HOLD;
    ctl.task_id = cmd_q.task_id;
    ctl.bit_sel = bit_idx;
    ctl.any_hit = |hit;

    case (state)
      atq_pkg::S_IDLE: begin
        if (accept) begin
          // every cell starts as a candidate if it is occupied
          ctl.op       = atq_pkg::OP_SCAN_LOAD;
          bit_idx_next = atq_pkg::BIT_W'(atq_pkg::WAIT_W - 1);
          if ((cmd.kind == atq_pkg::KIND_KILL) && !empty) begin
            state_next = atq_pkg::S_SCAN;
          end else begin
            state_next = atq_pkg::S_RUN;
          end
        end
      end

      atq_pkg::S_SCAN: begin
        // one wait bit per cycle, msb first
        ctl.op = atq_pkg::OP_SCAN;
        if (bit_idx == '0) begin
          state_next = atq_pkg::S_RUN;
        end else begin
          bit_idx_next = bit_idx - atq_pkg::BIT_W'(1);
        end
      end

      atq_pkg::S_RUN: begin
        state_next           = atq_pkg::S_IDLE;
        done_next            = 1'b1;
        result_next.status   = atq_pkg::STAT_DONE;
        result_next.out_id   = '0;
        result_next.out_wait = '0;

        case (cmd_q.kind)
          atq_pkg::KIND_ENQ: begin
            // id check comes before the full check
            if (dup) begin
              result_next.status = atq_pkg::STAT_DUP;
            end else if (full) begin
              result_next.status = atq_pkg::STAT_FULL;
            end else begin
              ctl.op     = atq_pkg::OP_PUSH;
              count_next = count + atq_pkg::CNT_W'(1);
            end
          end
          atq_pkg::KIND_EXEC: begin
            if (empty) begin
              result_next.status = atq_pkg::STAT_EMPTY;
            end else begin
              ctl.op               = atq_pkg::OP_POP;
              result_next.out_id   = slot_id[0];
              result_next.out_wait = slot_wait[0];
              count_next           = count - atq_pkg::CNT_W'(1);
            end
          end
          atq_pkg::KIND_KILL: begin
            if (empty) begin
              result_next.status = atq_pkg::STAT_EMPTY;
            end else begin
              ctl.op               = atq_pkg::OP_KILL;
              result_next.out_id   = kill_id;
              result_next.out_wait = kill_wait;
              count_next           = count - atq_pkg::CNT_W'(1);
            end
          end
          default: begin
          end
        endcase

        result_next.occupancy = atq_pkg::OCC_W'(count_next);
      end

      default: begin
        state_next = atq_pkg::S_IDLE;
      end
    endcase
  end

  assign kill_run = (state == atq_pkg::S_RUN) && (cmd_q.kind == atq_pkg::KIND_KILL) && !empty;
  assign push_now = (ctl.op == atq_pkg::OP_PUSH);

  // results only show while idle
  `ATQ_ASSERT_NOW(a_done_idle, done, !busy)
  // count stays within the queue depth
  `ATQ_ASSERT_NOW(a_count_bound, 1'b1, count <= atq_pkg::CNT_W'(N))
  // exactly one victim once the scan of a non-empty queue is over
  `ATQ_ASSERT_NOW(a_one_victim, kill_run, $onehot(first))
  // an append grows the queue by one
  `ATQ_ASSERT_NEXT(a_push_grows, push_now, count == $past(count) + atq_pkg::CNT_W'(1))
  // an accepted word makes the block busy, with no result in the next cycle
  `ATQ_ASSERT_NEXT(a_accept_busy, accept, busy && !done)

endmodule

@@ rtl/core/atq_cell.sv @@
// one queue slot: task id, wait counter and max-search candidate flag
// depends on atq_pkg
module atq_cell (
  input  logic                      clk,
  input  atq_pkg::cell_ctl_t        ctl,
  input  logic                      occ,
  input  logic                      tail,
  input  logic                      take_next,
  input  logic [atq_pkg::ID_W-1:0]  nxt_id,
  input  logic [atq_pkg::WAIT_W-1:0] nxt_wait,
  output logic [atq_pkg::ID_W-1:0]  slot_id,
  output logic [atq_pkg::WAIT_W-1:0] slot_wait,
  output logic                      match,
  output logic                      hit,
  output logic                      cand
);

  logic [atq_pkg::ID_W-1:0]   id_reg;
  logic [atq_pkg::WAIT_W-1:0] wait_cnt;
  logic                       cand_reg;

  assign slot_id   = id_reg;
  assign slot_wait = wait_cnt;
  assign cand      = cand_reg;
  assign match     = occ && (id_reg == ctl.task_id);
  assign hit       = cand_reg && wait_cnt[ctl.bit_sel];

  always_ff @(posedge clk) begin
    case (ctl.op)
      atq_pkg::OP_SCAN_LOAD: begin
        cand_reg <= occ;
      end
      atq_pkg::OP_SCAN: begin
        // drop out once some candidate has a one where this one has a zero
        cand_reg <= cand_reg && (wait_cnt[ctl.bit_sel] || !ctl.any_hit);
      end
      atq_pkg::OP_PUSH: begin
        if (tail) begin
          id_reg   <= ctl.task_id;
          wait_cnt <= atq_pkg::NEW_WAIT;
        end else if (occ && (wait_cnt != atq_pkg::WAIT_MAX)) begin
          wait_cnt <= wait_cnt + atq_pkg::WAIT_W'(1);
        end
      end
      atq_pkg::OP_POP: begin
        id_reg <= nxt_id;
        if (nxt_wait > atq_pkg::WAIT_W'(1)) begin
          wait_cnt <= nxt_wait - atq_pkg::WAIT_W'(1);
        end else begin
          wait_cnt <= nxt_wait;
        end
      end
      atq_pkg::OP_KILL: begin
        if (take_next) begin
          id_reg   <= nxt_id;
          wait_cnt <= nxt_wait;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
